// ===== src/indexed_max_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Indexed max priority queue assertion macros
// Assertion forms for the queue's port checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define INDEXED_MAX_PRIORITY_QUEUE_DEFINES_SVH

// property checked outside reset
`define IMPQ_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define IMPQ_CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/impq_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed max priority queue package
// Sizes, command and status codes, heap entry type and sequencer states.
// ----------------------------------------------------------------------------
package impq_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 3;
  localparam int ID_W     = 8;
  localparam int KEY_W    = 32;
  localparam int STAT_W   = 3;
  localparam int COUNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_RAISE  = 3'd1,
    CMD_LOWER  = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_PRESENT = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_ORDER   = 3'd4,
    ST_EMPTY   = 3'd5
  } status_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       id;
    logic signed [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_CHK  = 15'h0002,
    S_HK   = 15'h0004,
    S_HCMP = 15'h0008,
    S_RM1  = 15'h0010,
    S_RM2  = 15'h0020,
    S_UPR  = 15'h0040,
    S_UPC  = 15'h0080,
    S_DNL  = 15'h0100,
    S_DNR  = 15'h0200,
    S_DNC  = 15'h0400,
    S_WB   = 15'h0800,
    S_FIN  = 15'h1000,
    S_SP0  = 15'h2000,
    S_SP1  = 15'h4000
  } state_t;

endpackage

// ===== src/impq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module impq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/indexed_max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Indexed max priority queue
// Binary max-heap of keyed ids with an id-to-slot map, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: command, item id and new key. Result channel out_*:
//   status, id, key and the entry count after the request.
//   One request is worked at a time; in_stall stays high until its result
//   sits in the output register, and also while that register is stalled.
//   A sift works one heap level at a time through the heap RAM's single
//   read port: each level reads a parent, or a left then a right child.
//   Reset (synchronous, rst_n low) empties the queue: presence bits and the
//   count clear at once, no clearing pass is needed, the RAMs keep garbage.
//   While out_stall is high with a valid result, the result holds and no request is taken.
// ----------------------------------------------------------------------------
module indexed_max_priority_queue (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [impq_pkg::CMD_W-1:0]            in_command,
  input  logic [impq_pkg::ID_W-1:0]             in_item_id,
  input  logic signed [impq_pkg::KEY_W-1:0]     in_new_key,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [impq_pkg::STAT_W-1:0]           out_status,
  output logic [impq_pkg::ID_W-1:0]             out_result_id,
  output logic signed [impq_pkg::KEY_W-1:0]     out_result_key,
  output logic [impq_pkg::COUNT_W-1:0]          out_entry_count
);

  localparam int SW = impq_pkg::SLOT_W;
  localparam int CW = impq_pkg::SLOT_W + 2;

  impq_pkg::state_t                 state_r, state_nxt;
  logic [impq_pkg::CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [impq_pkg::ID_W-1:0]        id_r, id_nxt;
  logic signed [impq_pkg::KEY_W-1:0] nk_r, nk_nxt;
  impq_pkg::entry_t                 mov_r, mov_nxt;
  impq_pkg::entry_t                 lft_r, lft_nxt;
  logic [SW-1:0]                    k_r, k_nxt;
  logic [impq_pkg::CNT_W-1:0]       fill_r, fill_nxt;
  logic [impq_pkg::CAPACITY-1:0]    present_r, present_nxt;
  logic [impq_pkg::STAT_W-1:0]      res_status_r, res_status_nxt;
  logic [impq_pkg::ID_W-1:0]        res_id_r, res_id_nxt;
  logic signed [impq_pkg::KEY_W-1:0] res_key_r, res_key_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [impq_pkg::STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [impq_pkg::ID_W-1:0]        out_id_r, out_id_nxt;
  logic signed [impq_pkg::KEY_W-1:0] out_key_r, out_key_nxt;
  logic [impq_pkg::COUNT_W-1:0]     out_count_r, out_count_nxt;

  logic                             heap_we;
  logic [SW-1:0]                    heap_waddr, heap_raddr;
  impq_pkg::entry_t                 heap_wdata, heap_rdata;
  logic                             pos_we;
  logic [SW-1:0]                    pos_waddr, pos_raddr, pos_wdata, pos_rdata;

  logic [SW-1:0]                    idx, parent;
  logic                             id_ok, take_right;
  logic [CW-1:0]                    left_w, right_w, fill_w;
  impq_pkg::entry_t                 big;

  impq_ram #(.WIDTH($bits(impq_pkg::entry_t)), .DEPTH(impq_pkg::CAPACITY)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  impq_ram #(.WIDTH(SW), .DEPTH(impq_pkg::CAPACITY)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign in_stall = (state_r != impq_pkg::S_IDLE) || (out_valid_r && out_stall);

  assign idx        = id_r[SW-1:0];
  assign id_ok      = ((impq_pkg::ID_W+1)'(id_r) < (impq_pkg::ID_W+1)'(impq_pkg::CAPACITY));
  assign parent     = SW'((k_r - 1'b1) >> 1);
  assign left_w     = {1'b0, k_r, 1'b1};
  assign right_w    = CW'(left_w + 1'b1);
  assign fill_w     = CW'(fill_r);
  assign take_right = (right_w < fill_w) && ($signed(heap_rdata.key) > $signed(lft_r.key));
  assign big        = take_right ? heap_rdata : lft_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    nk_nxt         = nk_r;
    mov_nxt        = mov_r;
    lft_nxt        = lft_r;
    k_nxt          = k_r;
    fill_nxt       = fill_r;
    present_nxt    = present_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_key_nxt    = res_key_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_key_nxt    = out_key_r;
    out_count_nxt  = out_count_r;
    heap_we        = 1'b0;
    heap_waddr     = k_r;
    heap_wdata     = mov_r;
    heap_raddr     = '0;
    pos_we         = 1'b0;
    pos_waddr      = mov_r.id;
    pos_wdata      = k_r;
    pos_raddr      = idx;

    unique case (state_r)
      impq_pkg::S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd_nxt        = in_command;
          id_nxt         = in_item_id;
          nk_nxt         = in_new_key;
          res_status_nxt = impq_pkg::ST_OK;
          res_id_nxt     = in_item_id;
          res_key_nxt    = '0;
          state_nxt      = impq_pkg::S_CHK;
        end
      end
      impq_pkg::S_CHK: begin
        state_nxt = impq_pkg::S_FIN;
        unique case (cmd_r)
          impq_pkg::CMD_REMOVE: begin
            if (fill_r == '0) begin
              res_status_nxt = impq_pkg::ST_EMPTY;
            end else begin
              state_nxt = impq_pkg::S_RM1;
            end
          end
          impq_pkg::CMD_INSERT: begin
            if (!id_ok) begin
              res_status_nxt = impq_pkg::ST_RANGE;
            end else if (present_r[idx] || fill_r == impq_pkg::CNT_W'(impq_pkg::CAPACITY)) begin
              res_status_nxt = impq_pkg::ST_PRESENT;
            end else begin
              present_nxt[idx] = 1'b1;
              fill_nxt         = fill_r + 1'b1;
              mov_nxt.id       = idx;
              mov_nxt.key      = nk_r;
              k_nxt            = fill_r[SW-1:0];
              res_key_nxt      = nk_r;
              state_nxt        = impq_pkg::S_UPR;
            end
          end
          impq_pkg::CMD_RAISE, impq_pkg::CMD_LOWER, impq_pkg::CMD_QUERY: begin
            if (!id_ok) begin
              res_status_nxt = impq_pkg::ST_RANGE;
            end else if (!present_r[idx]) begin
              res_status_nxt = impq_pkg::ST_ABSENT;
            end else begin
              state_nxt = impq_pkg::S_HK;
            end
          end
          default: begin
            state_nxt = impq_pkg::S_FIN;
          end
        endcase
      end
      impq_pkg::S_HK: begin
        k_nxt      = pos_rdata;
        heap_raddr = pos_rdata;
        state_nxt  = impq_pkg::S_HCMP;
      end
      impq_pkg::S_HCMP: begin
        state_nxt   = impq_pkg::S_FIN;
        mov_nxt.id  = idx;
        mov_nxt.key = nk_r;
        priority if (cmd_r == impq_pkg::CMD_QUERY) begin
          res_key_nxt = heap_rdata.key;
        end else if (cmd_r == impq_pkg::CMD_RAISE) begin
          if ($signed(nk_r) > $signed(heap_rdata.key)) begin
            res_key_nxt = nk_r;
            state_nxt   = impq_pkg::S_UPR;
          end else begin
            res_status_nxt = impq_pkg::ST_ORDER;
          end
        end else begin
          if ($signed(heap_rdata.key) > $signed(nk_r)) begin
            res_key_nxt = nk_r;
            state_nxt   = impq_pkg::S_DNL;
          end else begin
            res_status_nxt = impq_pkg::ST_ORDER;
          end
        end
      end
      impq_pkg::S_RM1: begin
        lft_nxt    = heap_rdata;
        heap_raddr = SW'(fill_r - 1'b1);
        state_nxt  = impq_pkg::S_RM2;
      end
      impq_pkg::S_RM2: begin
        mov_nxt               = heap_rdata;
        fill_nxt              = fill_r - 1'b1;
        present_nxt[lft_r.id] = 1'b0;
        k_nxt                 = '0;
        res_id_nxt            = impq_pkg::ID_W'(lft_r.id);
        res_key_nxt           = lft_r.key;
        state_nxt             = impq_pkg::S_DNL;
      end
      impq_pkg::S_UPR: begin
        if (k_r == '0) begin
          state_nxt = impq_pkg::S_WB;
        end else begin
          heap_raddr = parent;
          state_nxt  = impq_pkg::S_UPC;
        end
      end
      impq_pkg::S_UPC: begin
        if ($signed(mov_r.key) > $signed(heap_rdata.key)) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = heap_rdata.id;
          k_nxt      = parent;
          state_nxt  = impq_pkg::S_UPR;
        end else begin
          state_nxt = impq_pkg::S_WB;
        end
      end
      impq_pkg::S_DNL: begin
        if (left_w >= fill_w) begin
          state_nxt = impq_pkg::S_WB;
        end else begin
          heap_raddr = left_w[SW-1:0];
          state_nxt  = impq_pkg::S_DNR;
        end
      end
      impq_pkg::S_DNR: begin
        lft_nxt    = heap_rdata;
        heap_raddr = right_w[SW-1:0];
        state_nxt  = impq_pkg::S_DNC;
      end
      impq_pkg::S_DNC: begin
        if ($signed(big.key) > $signed(mov_r.key)) begin
          heap_we    = 1'b1;
          heap_wdata = big;
          pos_we     = 1'b1;
          pos_waddr  = big.id;
          k_nxt      = take_right ? right_w[SW-1:0] : left_w[SW-1:0];
          state_nxt  = impq_pkg::S_DNL;
        end else begin
          state_nxt = impq_pkg::S_WB;
        end
      end
      impq_pkg::S_WB: begin
        heap_we   = 1'b1;
        pos_we    = 1'b1;
        state_nxt = impq_pkg::S_FIN;
      end
      impq_pkg::S_FIN: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status_r;
        out_id_nxt     = res_id_r;
        out_key_nxt    = res_key_r;
        out_count_nxt  = impq_pkg::COUNT_W'(fill_r);
        state_nxt      = impq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = impq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= impq_pkg::S_IDLE;
      fill_r      <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    nk_r         <= nk_nxt;
    mov_r        <= mov_nxt;
    lft_r        <= lft_nxt;
    k_r          <= k_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_key_r    <= res_key_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_key_r    <= out_key_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_id   = out_id_r;
  assign out_result_key  = out_key_r;
  assign out_entry_count = out_count_r;

endmodule

// ===== src/impq_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed max priority queue port checker
// Watches the top level's ports and flags results that break its rules.
// ----------------------------------------------------------------------------
`include "indexed_max_priority_queue_defines.svh"

module impq_props (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [impq_pkg::CMD_W-1:0]         in_command,
  input logic [impq_pkg::ID_W-1:0]          in_item_id,
  input logic signed [impq_pkg::KEY_W-1:0]  in_new_key,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [impq_pkg::STAT_W-1:0]        out_status,
  input logic [impq_pkg::ID_W-1:0]          out_result_id,
  input logic signed [impq_pkg::KEY_W-1:0]  out_result_key,
  input logic [impq_pkg::COUNT_W-1:0]       out_entry_count
);

  `IMPQ_CHK_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")
  `IMPQ_CHK(a_hold, out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_result_key) && $stable(out_entry_count), "stalled result changed")
  `IMPQ_CHK(a_count, out_valid |-> out_entry_count <= impq_pkg::COUNT_W'(impq_pkg::CAPACITY), "entry count above capacity")
  `IMPQ_CHK(a_err_key, out_valid && out_status != impq_pkg::ST_OK |-> out_result_key == '0, "rejected request carries a key")

endmodule

bind indexed_max_priority_queue impq_props u_impq_props (.*);

// ===== verif/impq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed max priority queue checker
// Watches both channels, keeps its own heap of the queue and compares every
// result with the oldest predicted one.
// ----------------------------------------------------------------------------
module impq_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [impq_pkg::CMD_W-1:0]        in_command,
  input  logic [impq_pkg::ID_W-1:0]         in_item_id,
  input  logic signed [impq_pkg::KEY_W-1:0] in_new_key,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [impq_pkg::STAT_W-1:0]       out_status,
  input  logic [impq_pkg::ID_W-1:0]         out_result_id,
  input  logic signed [impq_pkg::KEY_W-1:0] out_result_key,
  input  logic [impq_pkg::COUNT_W-1:0]      out_entry_count,
  output int                                fail_count,
  output int                                pending_count
);

  typedef struct packed {
    logic [impq_pkg::STAT_W-1:0]       status;
    logic [impq_pkg::ID_W-1:0]         id;
    logic signed [impq_pkg::KEY_W-1:0] key;
    logic [impq_pkg::COUNT_W-1:0]      count;
  } reply_t;

  reply_t                            reply_q[$];
  logic [impq_pkg::ID_W-1:0]         heap_ids [impq_pkg::CAPACITY];
  logic signed [impq_pkg::KEY_W-1:0] prio [impq_pkg::CAPACITY];
  int                                slot [impq_pkg::CAPACITY];
  bit                                held [impq_pkg::CAPACITY];
  int                                fill;

  function automatic bit higher(int s, int t);
    return prio[heap_ids[s]] > prio[heap_ids[t]];
  endfunction

  function automatic void swap_pos(int s, int t);
    logic [impq_pkg::ID_W-1:0] a;
    logic [impq_pkg::ID_W-1:0] b;
    a = heap_ids[s];
    b = heap_ids[t];
    heap_ids[s] = b;
    heap_ids[t] = a;
    slot[b] = s;
    slot[a] = t;
  endfunction

  function automatic void bubble_up(int k);
    while (k > 0 && higher(k, (k - 1) / 2)) begin
      swap_pos(k, (k - 1) / 2);
      k = (k - 1) / 2;
    end
  endfunction

  function automatic void bubble_down(int k);
    int big;
    forever begin
      if (2 * k + 1 >= fill) break;
      big = 2 * k + 1;
      if (2 * k + 2 < fill && higher(2 * k + 2, 2 * k + 1)) big = 2 * k + 2;
      if (!higher(big, k)) break;
      swap_pos(k, big);
      k = big;
    end
  endfunction

  function automatic reply_t apply_request(logic [impq_pkg::CMD_W-1:0] cmd,
                                           logic [impq_pkg::ID_W-1:0] id,
                                           logic signed [impq_pkg::KEY_W-1:0] nk);
    reply_t r;
    r = '{status: impq_pkg::ST_OK, id: id, key: '0, count: '0};
    if (cmd == impq_pkg::CMD_REMOVE) begin
      if (fill == 0) r.status = impq_pkg::ST_EMPTY;
      else begin
        r.id = heap_ids[0];
        r.key = prio[heap_ids[0]];
        held[heap_ids[0]] = 0;
        swap_pos(0, fill - 1);
        fill--;
        bubble_down(0);
      end
    end else if (cmd <= impq_pkg::CMD_QUERY) begin
      if (id >= impq_pkg::CAPACITY) r.status = impq_pkg::ST_RANGE;
      else if (cmd == impq_pkg::CMD_INSERT) begin
        if (held[id] || fill >= impq_pkg::CAPACITY) r.status = impq_pkg::ST_PRESENT;
        else begin
          held[id] = 1;
          prio[id] = nk;
          heap_ids[fill] = id;
          slot[id] = fill;
          fill++;
          bubble_up(fill - 1);
          r.key = nk;
        end
      end else if (!held[id]) r.status = impq_pkg::ST_ABSENT;
      else if (cmd == impq_pkg::CMD_QUERY) r.key = prio[id];
      else if (cmd == impq_pkg::CMD_RAISE) begin
        if (!(nk > prio[id])) r.status = impq_pkg::ST_ORDER;
        else begin
          prio[id] = nk;
          bubble_up(slot[id]);
          r.key = nk;
        end
      end else begin
        if (!(prio[id] > nk)) r.status = impq_pkg::ST_ORDER;
        else begin
          prio[id] = nk;
          bubble_down(slot[id]);
          r.key = nk;
        end
      end
    end
    r.count = impq_pkg::COUNT_W'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < impq_pkg::CAPACITY; i++) held[i] = 0;
      fill = 0;
      fail_count = 0;
      reply_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result id %0d", out_result_id);
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status || out_result_id !== want.id ||
              out_result_key !== want.key || out_entry_count !== want.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp st %0d id %0d key %0d cnt %0d, got %0d %0d %0d %0d",
                       want.status, want.id, want.key, want.count, out_status,
                       out_result_id, out_result_key, out_entry_count);
          end
        end
      end
      if (in_valid && !in_stall)
        reply_q.push_back(apply_request(in_command, in_item_id, in_new_key));
    end
    pending_count = reply_q.size();
  end
endmodule

// ===== verif/tb_indexed_max_priority_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed max priority queue testbench
// Directed corner requests then mostly valid random heap traffic with
// bursty sending and a stalling receiver; the checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_max_priority_queue;

  localparam int WATCHDOG = 20000;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [impq_pkg::CMD_W-1:0]        in_command;
  logic [impq_pkg::ID_W-1:0]         in_item_id;
  logic signed [impq_pkg::KEY_W-1:0] in_new_key;
  logic                              out_valid;
  logic                              out_stall;
  logic [impq_pkg::STAT_W-1:0]       out_status;
  logic [impq_pkg::ID_W-1:0]         out_result_id;
  logic signed [impq_pkg::KEY_W-1:0] out_result_key;
  logic [impq_pkg::COUNT_W-1:0]      out_entry_count;
  int                                fail_count;
  int                                pending_count;
  int                                idle_cycles;
  bit                                hold_off;

  indexed_max_priority_queue uut (.*);
  impq_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if ($urandom_range(0, 3) == 0) out_stall <= $urandom_range(0, 2) != 0;
      else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(logic [impq_pkg::CMD_W-1:0] cmd, logic [impq_pkg::ID_W-1:0] id,
                              logic signed [impq_pkg::KEY_W-1:0] nk);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_item_id <= id;
    in_new_key <= nk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic logic [impq_pkg::CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return impq_pkg::CMD_INSERT;
    if (r < 50) return impq_pkg::CMD_RAISE;
    if (r < 65) return impq_pkg::CMD_LOWER;
    if (r < 85) return impq_pkg::CMD_REMOVE;
    if (r < 97) return impq_pkg::CMD_QUERY;
    return impq_pkg::CMD_W'($urandom_range(5, 7));
  endfunction

  function automatic logic signed [impq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return impq_pkg::KEY_W'($urandom_range(0, 7)) - 4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int burst;
    int sent;
    logic [impq_pkg::ID_W-1:0] id;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= impq_pkg::CMD_INSERT;
    in_item_id   <= '0;
    in_new_key   <= '0;
    hold_off     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_request(impq_pkg::CMD_REMOVE, 8'd7, 0);
    send_request(impq_pkg::CMD_QUERY, 8'd3, 0);
    send_request(impq_pkg::CMD_INSERT, 8'd255, 5);
    send_request(impq_pkg::CMD_RAISE, 8'd16, 5);
    send_request(impq_pkg::CMD_INSERT, 8'd0, 32'sh80000000);
    send_request(impq_pkg::CMD_INSERT, 8'd0, 1);
    send_request(impq_pkg::CMD_INSERT, 8'd15, 32'sh7fffffff);
    send_request(impq_pkg::CMD_INSERT, 8'd5, 32'sh7fffffff);
    send_request(impq_pkg::CMD_RAISE, 8'd15, 32'sh7fffffff);
    send_request(impq_pkg::CMD_LOWER, 8'd0, 32'sh80000000);
    send_request(impq_pkg::CMD_LOWER, 8'd15, -1);
    send_request(impq_pkg::CMD_RAISE, 8'd0, 32'sh55555555);
    send_request(impq_pkg::CMD_QUERY, 8'd0, 0);
    send_request(impq_pkg::CMD_LOWER, 8'd9, 0);
    send_request(3'd5, 8'd170, 32'shaaaaaaaa);
    send_request(3'd7, 8'd85, 32'sh55555555);
    send_request(impq_pkg::CMD_REMOVE, 8'd0, 0);
    send_request(impq_pkg::CMD_REMOVE, 8'd0, 0);
    send_request(impq_pkg::CMD_REMOVE, 8'd0, 0);
    send_request(impq_pkg::CMD_REMOVE, 8'd0, 0);
    for (int i = 0; i < impq_pkg::CAPACITY; i++)
      send_request(impq_pkg::CMD_INSERT, impq_pkg::ID_W'(i), 7);
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
    join_none
    send_request(impq_pkg::CMD_INSERT, 8'd3, 9);
    send_request(impq_pkg::CMD_REMOVE, 8'd0, 0);
    send_request(impq_pkg::CMD_REMOVE, 8'd0, 0);
    sent = 0;
    while (sent < 900) begin
      burst = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        id = $urandom_range(0, 19) == 0 ? impq_pkg::ID_W'($urandom)
                                        : impq_pkg::ID_W'($urandom_range(0, 15));
        send_request(pick_cmd(), id, pick_key());
        sent++;
      end
      pause_sender();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
